// File: rtl/assert_macros.svh
// Assertion macros for the attribute pixel mapper.
// Uses clk and arst_n from the including module's scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define VAPM_ASSERT(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("vapm assertion failed");
`define VAPM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vapm assertion failed");
`else
`define VAPM_ASSERT(lbl, expr)
`define VAPM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: rtl/vapm_pkg.sv
// Shared types, register indexes and constants for the attribute pixel mapper.
// No dependencies.
package vapm_pkg;

	localparam int CIDX_W = 4;
	localparam int PAL_W  = 48;
	localparam int REG_IDX_W = 3;

	localparam logic [REG_IDX_W-1:0] REG_MODE      = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_UL_ROW    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_PAL_EN    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_PLANE_EN  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_COLOR_SEL = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_PAL_LOW   = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_PAL_HIGH  = 3'd6;

	localparam logic [7:0] UL_MASK  = 8'h73;
	localparam logic [7:0] UL_MATCH = 8'h01;

	typedef logic [CIDX_W-1:0] cidx_t;

	typedef struct packed {
		logic [7:0] attr_byte;
		logic [4:0] char_row;
		logic       blink_phase;
		logic       font_pixel;
	} pix_in_t;

	typedef struct packed {
		logic [7:0] dac_index;
		logic       pixel_ready;
	} pix_out_t;

	typedef struct packed {
		logic [3:0]       mode_control;
		logic [4:0]       underline_row;
		logic             palette_enable;
		logic [3:0]       plane_enable;
		logic [3:0]       color_select;
		logic [PAL_W-1:0] palette_low;
		logic [PAL_W-1:0] palette_high;
	} cfg_t;

	typedef struct packed {
		logic [1:0] level;
		logic       full;
	} q_stat_t;

	// 6-bit internal palette entry for a 4-bit color index
	function automatic logic [5:0] palette_entry(input cfg_t cfg, input cidx_t idx);
		logic [PAL_W-1:0] w;
		logic [5:0] e;
		w = idx[3] ? cfg.palette_high : cfg.palette_low;
		case (idx[2:0])
			3'd0: e = w[5:0];
			3'd1: e = w[11:6];
			3'd2: e = w[17:12];
			3'd3: e = w[23:18];
			3'd4: e = w[29:24];
			3'd5: e = w[35:30];
			3'd6: e = w[41:36];
			3'd7: e = w[47:42];
			default: e = '0;
		endcase
		return e;
	endfunction

endpackage

// File: rtl/vga_attribute_pixel_mapper_core.sv
// Attribute pixel mapper top: config registers, front, queue, back.
// A pixel accepted passes the front register, the queue and the output register before it is offered on dac.
// Throughput: one pixel per cycle while dac_ready does not stall the output; front
// register, two-entry queue and the output register each move one item a cycle.
// Reset: registers take their reset values, packing state and queue clear.
// Depends on vapm_pkg, vapm_front, vapm_queue, vapm_back, assert_macros.svh.
`include "assert_macros.svh"
module vga_attribute_pixel_mapper_core import vapm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [PAL_W-1:0]     cfg_data,
	input  logic                 pix_valid,
	output logic                 pix_ready,
	input  pix_in_t              pix,
	output logic                 dac_valid,
	input  logic                 dac_ready,
	output pix_out_t             dac
);

	cfg_t    cfg_q;
	logic    f_valid, f_ready, q_valid, q_ready;
	cidx_t   f_idx, q_idx;
	q_stat_t q_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode_control   <= '0;
			cfg_q.underline_row  <= '0;
			cfg_q.palette_enable <= 1'b0;
			cfg_q.plane_enable   <= 4'hF;
			cfg_q.color_select   <= '0;
			cfg_q.palette_low    <= '0;
			cfg_q.palette_high   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:      cfg_q.mode_control   <= cfg_data[3:0];
				REG_UL_ROW:    cfg_q.underline_row  <= cfg_data[4:0];
				REG_PAL_EN:    cfg_q.palette_enable <= cfg_data[0];
				REG_PLANE_EN:  cfg_q.plane_enable   <= cfg_data[3:0];
				REG_COLOR_SEL: cfg_q.color_select   <= cfg_data[3:0];
				REG_PAL_LOW:   cfg_q.palette_low    <= cfg_data;
				REG_PAL_HIGH:  cfg_q.palette_high   <= cfg_data;
				default: ;
			endcase
		end
	end

	vapm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix),
		.idx_valid (f_valid),
		.idx_ready (f_ready),
		.idx       (f_idx)
	);

	vapm_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_data  (f_idx),
		.rd_valid (q_valid),
		.rd_ready (q_ready),
		.rd_data  (q_idx),
		.stat     (q_stat)
	);

	vapm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.idx_valid (q_valid),
		.idx_ready (q_ready),
		.idx       (q_idx),
		.dac_valid (dac_valid),
		.dac_ready (dac_ready),
		.dac       (dac)
	);

	`VAPM_ASSERT(a_q_level, q_stat.level != 2'd3 && q_stat.full == (q_stat.level == 2'd2))
	`VAPM_ASSERT_NEXT(a_accept_front, pix_valid && pix_ready, f_valid)
	`VAPM_ASSERT_NEXT(a_out_from_q, !dac_valid && !q_valid, !dac_valid)

endmodule

// File: rtl/vapm_front.sv
// Front stage: accepts pixels, resolves foreground/background, masks planes.
// Depends on vapm_pkg.
module vapm_front import vapm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    pix_valid,
	output logic    pix_ready,
	input  pix_in_t pix,
	output logic    idx_valid,
	input  logic    idx_ready,
	output cidx_t   idx
);

	logic  valid_s1;
	cidx_t idx_s1;
	logic  text_mode, blink_en, fg;
	logic  [3:0] back_src;
	cidx_t cidx;

	always_comb begin
		text_mode = ~cfg.mode_control[0];
		blink_en  = cfg.mode_control[1];
		back_src  = text_mode ? pix.attr_byte[7:4] : pix.attr_byte[3:0];
		fg = pix.font_pixel;
		if (text_mode && pix.char_row == cfg.underline_row &&
		    (pix.attr_byte & UL_MASK) == UL_MATCH) begin
			fg = 1'b1;
		end
		if (blink_en && back_src[3] && !pix.blink_phase) begin
			fg = 1'b0;
		end
		if (fg) begin
			cidx = pix.attr_byte[3:0];
		end else begin
			cidx = {back_src[3] & ~blink_en, back_src[2:0]};
		end
		cidx = cidx & cfg.plane_enable;
	end

	assign pix_ready = ~valid_s1 | idx_ready;
	assign idx_valid = valid_s1;
	assign idx       = idx_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix_ready) begin
			valid_s1 <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_valid && pix_ready) begin
			idx_s1 <= cidx;
		end
	end

endmodule

// File: rtl/vapm_queue.sv
// Two-entry queue of color indexes between front and back.
// Depends on vapm_pkg.
module vapm_queue import vapm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    wr_valid,
	output logic    wr_ready,
	input  cidx_t   wr_data,
	output logic    rd_valid,
	input  logic    rd_ready,
	output cidx_t   rd_data,
	output q_stat_t stat
);

	cidx_t      data_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] level_q;
	logic       push, pop;

	assign wr_ready = (level_q != 2'd2);
	assign rd_valid = (level_q != 2'd0);
	assign rd_data  = data_q[rd_ptr_q];
	assign push     = wr_valid & wr_ready;
	assign pop      = rd_valid & rd_ready;

	assign stat.level = level_q;
	assign stat.full  = ~wr_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			level_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   level_q <= level_q + 2'd1;
				2'b01:   level_q <= level_q - 2'd1;
				default: level_q <= level_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			data_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// File: rtl/vapm_back.sv
// Back stage: palette / color-select translation, 8-bit packing, output register.
// Depends on vapm_pkg.
module vapm_back import vapm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     idx_valid,
	output logic     idx_ready,
	input  cidx_t    idx,
	output logic     dac_valid,
	input  logic     dac_ready,
	output pix_out_t dac
);

	logic       out_valid_q;
	pix_out_t   out_q;
	logic       phase_q;
	logic [7:0] packed_q;
	logic [5:0] entry;
	logic [7:0] v;
	logic       eight, take;

	always_comb begin
		eight = cfg.mode_control[3];
		entry = palette_entry(cfg, idx);
		if (cfg.palette_enable) begin
			if (eight) begin
				v = {4'h0, entry[3:0]};
			end else begin
				v = {cfg.color_select[3:2],
				     cfg.mode_control[2] ? cfg.color_select[1:0] : entry[5:4],
				     entry[3:0]};
			end
		end else begin
			v = {4'h0, idx};
		end
	end

	assign take      = idx_valid & idx_ready;
	assign idx_ready = ~out_valid_q | dac_ready;
	assign dac_valid = out_valid_q;
	assign dac       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q     <= 1'b0;
			packed_q    <= '0;
		end else begin
			if (idx_ready) out_valid_q <= idx_valid;
			if (take && eight) begin
				phase_q  <= ~phase_q;
				packed_q <= {packed_q[3:0], v[3:0]};
			end
		end
	end

	// pair completes when the phase wraps back to zero
	always_ff @(posedge clk) begin
		if (take) begin
			if (eight) begin
				out_q.dac_index   <= {packed_q[3:0], v[3:0]};
				out_q.pixel_ready <= phase_q;
			end else begin
				out_q.dac_index   <= v;
				out_q.pixel_ready <= 1'b1;
			end
		end
	end

endmodule

// File: sim/vapm_tb_pkg.sv
// Mode control bit masks shared by the pixel mapper testbench and its checker.
// No dependencies.
package vapm_tb_pkg;

	localparam logic [3:0] MODE_GFX   = 4'h1;
	localparam logic [3:0] MODE_BLINK = 4'h2;
	localparam logic [3:0] MODE_SEL54 = 4'h4;
	localparam logic [3:0] MODE_EIGHT = 4'h8;

endpackage

// File: sim/vapm_checker.sv
// Checker for the attribute pixel mapper: tracks register writes, predicts the DAC
// result of every accepted pixel and compares it with what the block returns.
// Depends on vapm_pkg and vapm_tb_pkg.
module vapm_checker import vapm_pkg::*, vapm_tb_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [PAL_W-1:0]     cfg_data,
	input  logic                 pix_valid,
	input  logic                 pix_ready,
	input  pix_in_t              pix,
	input  logic                 dac_valid,
	input  logic                 dac_ready,
	input  pix_out_t             dac,
	output int                   pending,
	output int                   mismatches
);
	timeunit 1ns;
	timeprecision 1ps;

	cfg_t       shadow;
	logic       nibble_odd = 1'b0;
	logic [7:0] packed_pair = 8'h00;
	pix_out_t   dac_expected[$];
	int         fail_total = 0;

	assign mismatches = fail_total;

	task automatic report_mismatch(input string msg);
		$display("%0t ns: %s", $time, msg);
		fail_total++;
	endtask

	// Foreground/background resolution, color lookup plus eight-bit packing; advances the packing state.
	function automatic pix_out_t predict_dac(input pix_in_t p);
		logic        text_mode, blink_en, fg;
		logic [7:0]  back_src, idx;
		logic [5:0]  entry;
		logic [PAL_W-1:0] word;
		pix_out_t    r;
		text_mode = (shadow.mode_control & MODE_GFX) == '0;
		blink_en  = (shadow.mode_control & MODE_BLINK) != '0;
		back_src  = text_mode ? {4'h0, p.attr_byte[7:4]} : p.attr_byte;
		fg = p.font_pixel;
		if (!fg && text_mode && p.char_row == shadow.underline_row
				&& (p.attr_byte & UL_MASK) == UL_MATCH)
			fg = 1'b1;
		if (blink_en && back_src[3] && !p.blink_phase)
			fg = 1'b0;
		idx = fg ? p.attr_byte : (back_src & (blink_en ? 8'h07 : 8'h0F));
		idx &= {4'h0, shadow.plane_enable};
		if (shadow.palette_enable) begin
			word  = idx[3] ? shadow.palette_high : shadow.palette_low;
			entry = word[idx[2:0]*6 +: 6];
			if ((shadow.mode_control & MODE_EIGHT) != '0) begin
				idx = {4'h0, entry[3:0]};
			end else begin
				idx = {2'b00, entry};
				if ((shadow.mode_control & MODE_SEL54) != '0)
					idx[5:4] = shadow.color_select[1:0];
				idx[7:6] = shadow.color_select[3:2];
			end
		end
		if ((shadow.mode_control & MODE_EIGHT) != '0) begin
			packed_pair = {packed_pair[3:0], idx[3:0]};
			nibble_odd  = ~nibble_odd;
			r.dac_index   = packed_pair;
			r.pixel_ready = ~nibble_odd;
		end else begin
			r.dac_index   = idx;
			r.pixel_ready = 1'b1;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pix_out_t want;
		if (!arst_n) begin
			shadow = '0;
			shadow.plane_enable = 4'hF;
			nibble_odd  = 1'b0;
			packed_pair = 8'h00;
			dac_expected.delete();
			pending <= 0;
		end else begin
			if (dac_valid && dac_ready) begin
				if (dac_expected.size() == 0) begin
					report_mismatch($sformatf("dac 0x%0h ready %0b with no request outstanding",
						dac.dac_index, dac.pixel_ready));
				end else begin
					want = dac_expected.pop_front();
					if (dac.dac_index !== want.dac_index)
						report_mismatch($sformatf("dac_index got 0x%0h expected 0x%0h",
							dac.dac_index, want.dac_index));
					if (dac.pixel_ready !== want.pixel_ready)
						report_mismatch($sformatf("pixel_ready got %0b expected %0b",
							dac.pixel_ready, want.pixel_ready));
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_MODE:      shadow.mode_control   = cfg_data[3:0];
					REG_UL_ROW:    shadow.underline_row  = cfg_data[4:0];
					REG_PAL_EN:    shadow.palette_enable = cfg_data[0];
					REG_PLANE_EN:  shadow.plane_enable   = cfg_data[3:0];
					REG_COLOR_SEL: shadow.color_select   = cfg_data[3:0];
					REG_PAL_LOW:   shadow.palette_low    = cfg_data;
					REG_PAL_HIGH:  shadow.palette_high   = cfg_data;
					default: ;
				endcase
			end
			if (pix_valid && pix_ready)
				dac_expected.push_back(predict_dac(pix));
			pending <= dac_expected.size();
		end
	end

endmodule

// File: sim/tb.sv
// Top of the attribute pixel mapper testbench: clock, reset, register setups,
// pixel stimulus with bursts and output stalls, and the verdict.
// Depends on vapm_pkg, vapm_tb_pkg, vapm_checker and vga_attribute_pixel_mapper_core.
module tb import vapm_pkg::*, vapm_tb_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	// index past the register list, must be ignored
	localparam logic [REG_IDX_W-1:0] REG_SPARE = 3'd7;

	typedef enum logic [1:0] {RX_STEADY, RX_TOGGLE, RX_RANDOM} rx_style_t;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index = REG_MODE;
	logic [PAL_W-1:0]     cfg_data = '0;
	logic                 pix_valid = 1'b0;
	logic                 pix_ready;
	pix_in_t              pix = '0;
	logic                 dac_valid;
	logic                 dac_ready = 1'b0;
	pix_out_t             dac;
	int                   pending;
	int                   mismatches;

	int         burst_left = 0;
	int         gap_max = 0;
	logic [4:0] ul_row_now = 5'd0;
	int         rx_cycle = 0;
	int         rx_hold = 0;
	rx_style_t  rx_style = RX_STEADY;

	vga_attribute_pixel_mapper_core uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.pix_valid(pix_valid), .pix_ready(pix_ready), .pix(pix),
		.dac_valid(dac_valid), .dac_ready(dac_ready), .dac(dac)
	);

	vapm_checker chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.pix_valid(pix_valid), .pix_ready(pix_ready), .pix(pix),
		.dac_valid(dac_valid), .dac_ready(dac_ready), .dac(dac),
		.pending(pending), .mismatches(mismatches)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// output side stalls: steady, toggling, or random holds
	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 1;
		if (rx_cycle % 256 == 0)
			rx_style <= rx_style_t'($urandom_range(0, 2));
		case (rx_style)
			RX_STEADY: dac_ready <= 1'b1;
			RX_TOGGLE: dac_ready <= ~dac_ready;
			default: begin
				if (rx_hold != 0) begin
					dac_ready <= 1'b0;
					rx_hold <= rx_hold - 1;
				end else begin
					dac_ready <= 1'b1;
					if ($urandom_range(0, 3) == 0)
						rx_hold <= $urandom_range(1, 6);
				end
			end
		endcase
	end

	// leaves cfg_we high; the caller lowers it after its last write
	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [PAL_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	task automatic load_setup(input logic [3:0] mode, input logic [4:0] ul, input logic pal_en,
			input logic [3:0] planes, input logic [3:0] csel,
			input logic [PAL_W-1:0] pal_lo, input logic [PAL_W-1:0] pal_hi);
		write_reg(REG_MODE, PAL_W'(mode));
		write_reg(REG_UL_ROW, PAL_W'(ul));
		write_reg(REG_PAL_EN, PAL_W'(pal_en));
		write_reg(REG_PLANE_EN, PAL_W'(planes));
		write_reg(REG_COLOR_SEL, PAL_W'(csel));
		write_reg(REG_PAL_LOW, pal_lo);
		write_reg(REG_PAL_HIGH, pal_hi);
		cfg_we <= 1'b0;
		ul_row_now = ul;
	endtask

	task automatic send_pixel(input pix_in_t p);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (gap_max != 0) begin
				pix_valid <= 1'b0;
				repeat ($urandom_range(1, gap_max)) @(posedge clk);
			end
		end
		burst_left--;
		pix_valid <= 1'b1;
		pix <= p;
		do @(posedge clk); while (!pix_ready);
	endtask

	task automatic drain();
		pix_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// biased toward the underline row and underline-shaped attributes
	function automatic pix_in_t next_pixel();
		pix_in_t p;
		p = $bits(pix_in_t)'($urandom);
		if ($urandom_range(0, 2) == 0)
			p.char_row = ul_row_now;
		if ($urandom_range(0, 3) == 0)
			p.attr_byte = (p.attr_byte & ~UL_MASK) | UL_MATCH;
		return p;
	endfunction

	initial begin
		int n;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setup: text mode, no palette, all planes
		send_pixel({8'h00, 5'd0, 1'b0, 1'b0});
		send_pixel({8'hFF, 5'd31, 1'b1, 1'b1});
		send_pixel({8'hF0, 5'd31, 1'b0, 1'b0});
		send_pixel({8'h01, 5'd0, 1'b0, 1'b0});
		send_pixel({8'h01, 5'd1, 1'b0, 1'b0});
		drain();

		load_setup(MODE_BLINK, 5'd31, 1'b0, 4'hF, 4'h0, '0, '0);
		send_pixel({8'h81, 5'd3, 1'b0, 1'b1});
		send_pixel({8'h81, 5'd3, 1'b1, 1'b1});
		send_pixel({8'h71, 5'd31, 1'b0, 1'b0});
		send_pixel({8'h89, 5'd31, 1'b0, 1'b0});
		send_pixel({8'h8D, 5'd31, 1'b1, 1'b0});
		drain();

		// graphics: blink bit is attribute bit 3, no underline
		load_setup(MODE_GFX | MODE_BLINK, 5'd0, 1'b0, 4'hF, 4'h0, '0, '0);
		send_pixel({8'h08, 5'd0, 1'b0, 1'b1});
		send_pixel({8'h0F, 5'd0, 1'b1, 1'b0});
		send_pixel({8'h01, 5'd0, 1'b0, 1'b0});
		drain();

		load_setup(MODE_SEL54, 5'd0, 1'b1, 4'h0, 4'hF, '1, 48'h0123_4567_89AB);
		send_pixel({8'hFF, 5'd0, 1'b1, 1'b1});
		drain();

		write_reg(REG_SPARE, '1);
		load_setup(MODE_EIGHT, 5'd0, 1'b1, 4'hF, 4'h5, 48'h0123_4567_89AB, 48'hFEDC_BA98_7654);
		send_pixel({8'h0C, 5'd2, 1'b0, 1'b1});
		send_pixel({8'h3A, 5'd2, 1'b1, 1'b0});
		send_pixel({8'hE7, 5'd9, 1'b1, 1'b1});
		drain();
		// leave eight-bit mode halfway through a pair, then come back
		write_reg(REG_MODE, PAL_W'(MODE_SEL54));
		cfg_we <= 1'b0;
		send_pixel({8'h5B, 5'd4, 1'b0, 1'b1});
		drain();
		write_reg(REG_MODE, PAL_W'(MODE_EIGHT));
		cfg_we <= 1'b0;
		send_pixel({8'hA6, 5'd4, 1'b1, 1'b0});
		drain();

		for (int ph = 0; ph < 12; ph++) begin
			case (ph)
				0: load_setup(4'h0, 5'd0, 1'b0, 4'h0, 4'h0, '0, '0);
				1: load_setup(4'hF, 5'd31, 1'b1, 4'hF, 4'hF, '1, '1);
				2: load_setup(MODE_BLINK | MODE_SEL54, 5'd31, 1'b1, 4'hF, 4'hF,
					PAL_W'({$urandom, $urandom}), PAL_W'({$urandom, $urandom}));
				3: load_setup(MODE_EIGHT, 5'd7, 1'b0, 4'hF, 4'h0, '0, '0);
				default: load_setup(4'($urandom_range(0, 15)), 5'($urandom_range(0, 31)),
					$urandom_range(0, 3) != 0,
					($urandom_range(0, 1) != 0) ? 4'hF : 4'($urandom_range(0, 15)),
					4'($urandom_range(0, 15)),
					PAL_W'({$urandom, $urandom}), PAL_W'({$urandom, $urandom}));
			endcase
			gap_max = (ph % 3 == 0) ? 0 : $urandom_range(2, 8);
			n = $urandom_range(50, 90);
			repeat (n) send_pixel(next_pixel());
			drain();
		end

		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#1_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl
rtl/vapm_pkg.sv
rtl/vapm_front.sv
rtl/vapm_queue.sv
rtl/vapm_back.sv
rtl/vga_attribute_pixel_mapper_core.sv
sim/vapm_tb_pkg.sv
sim/vapm_checker.sv
sim/tb.sv
